[rtl/hrp_pkg.sv]
// Shared types, codes and character-class functions for the HTTP request head parser.
package hrp_pkg;

    // Grammar position, one-hot.
    typedef enum logic [17:0] {
        PH_METHOD_START = 18'h00001,
        PH_METHOD       = 18'h00002,
        PH_URI          = 18'h00004,
        PH_V_H          = 18'h00008,
        PH_V_T1         = 18'h00010,
        PH_V_T2         = 18'h00020,
        PH_V_P          = 18'h00040,
        PH_V_SLASH      = 18'h00080,
        PH_MAJOR_START  = 18'h00100,
        PH_MAJOR        = 18'h00200,
        PH_MINOR_START  = 18'h00400,
        PH_MINOR        = 18'h00800,
        PH_NL_1         = 18'h01000,
        PH_LINE_START   = 18'h02000,
        PH_NAME         = 18'h04000,
        PH_VALUE        = 18'h08000,
        PH_NL_2         = 18'h10000,
        PH_NL_3         = 18'h20000
    } t_phase;

    localparam logic [2:0] K_NONE    = 3'd0;
    localparam logic [2:0] K_METHOD  = 3'd1;
    localparam logic [2:0] K_URI     = 3'd2;
    localparam logic [2:0] K_VERSION = 3'd3;
    localparam logic [2:0] K_NAME    = 3'd4;
    localparam logic [2:0] K_VALUE   = 3'd5;

    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_new;
    } t_in_req;

    typedef struct packed {
        logic [2:0] field_kind;
        logic [7:0] out_byte;
        logic       insert_space;
        logic       header_done;
        logic [1:0] status;
    } t_out_rsp;

    typedef struct packed {
        t_phase     phase;
        logic       name_seen;
        logic       value_seen;
        logic       space_pending;
        logic [1:0] final_status;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:         PH_METHOD_START,
        name_seen:     1'b0,
        value_seen:    1'b0,
        space_pending: 1'b0,
        final_status:  ST_MORE
    };

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= 8'd31) || (c == 8'd127);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        logic r;
        case (c)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
            8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20,
            8'h09: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !is_sep(c);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

[rtl/hrp_step.sv]
// One-byte grammar step: next parser state and the result for one request.
module hrp_step (
    input  hrp_pkg::t_state   i_state,
    input  hrp_pkg::t_in_req  i_req,
    output hrp_pkg::t_state   o_state,
    output hrp_pkg::t_out_rsp o_rsp
);
    import hrp_pkg::*;

    t_state     cur;
    t_state     nxt;
    logic [7:0] c;
    logic [2:0] kind;
    logic       ins;
    logic       hdone;
    logic [1:0] st;
    logic       is_ws;

    assign c     = i_req.data_byte;
    assign is_ws = (c == CH_SPACE) || (c == CH_TAB);

    always_comb begin
        cur   = i_req.start_new ? STATE_RESET : i_state;
        nxt   = cur;
        kind  = K_NONE;
        ins   = 1'b0;
        hdone = 1'b0;
        st    = ST_MORE;
        if (cur.final_status != ST_MORE) begin
            st = cur.final_status;
        end else begin
            case (cur.phase)
                PH_METHOD_START: begin
                    if (is_token(c)) begin
                        kind      = K_METHOD;
                        nxt.phase = PH_METHOD;
                    end else st = ST_ERR;
                end
                PH_METHOD: begin
                    if (c == CH_SPACE) nxt.phase = PH_URI;
                    else if (is_token(c)) kind = K_METHOD;
                    else st = ST_ERR;
                end
                PH_URI: begin
                    if (c == CH_SPACE) nxt.phase = PH_V_H;
                    else if (is_ctl(c)) st = ST_ERR;
                    else kind = K_URI;
                end
                PH_V_H: begin
                    if (c == CH_H) begin
                        kind = K_VERSION; nxt.phase = PH_V_T1;
                    end else st = ST_ERR;
                end
                PH_V_T1: begin
                    if (c == CH_T) begin
                        kind = K_VERSION; nxt.phase = PH_V_T2;
                    end else st = ST_ERR;
                end
                PH_V_T2: begin
                    if (c == CH_T) begin
                        kind = K_VERSION; nxt.phase = PH_V_P;
                    end else st = ST_ERR;
                end
                PH_V_P: begin
                    if (c == CH_P) begin
                        kind = K_VERSION; nxt.phase = PH_V_SLASH;
                    end else st = ST_ERR;
                end
                PH_V_SLASH: begin
                    if (c == CH_SLASH) begin
                        kind = K_VERSION; nxt.phase = PH_MAJOR_START;
                    end else st = ST_ERR;
                end
                PH_MAJOR_START: begin
                    if (is_numeral(c)) begin
                        kind = K_VERSION; nxt.phase = PH_MAJOR;
                    end else st = ST_ERR;
                end
                PH_MAJOR: begin
                    if (c == CH_DOT) begin
                        kind = K_VERSION; nxt.phase = PH_MINOR_START;
                    end else if (is_numeral(c)) kind = K_VERSION;
                    else st = ST_ERR;
                end
                PH_MINOR_START: begin
                    if (is_numeral(c)) begin
                        kind = K_VERSION; nxt.phase = PH_MINOR;
                    end else st = ST_ERR;
                end
                PH_MINOR: begin
                    if (c == CH_CR) nxt.phase = PH_NL_1;
                    else if (is_numeral(c)) kind = K_VERSION;
                    else st = ST_ERR;
                end
                PH_NL_1, PH_NL_2: begin
                    if (c == CH_LF) nxt.phase = PH_LINE_START;
                    else st = ST_ERR;
                end
                PH_LINE_START: begin
                    if (is_ws) begin
                        // folded continuation
                        if (!cur.name_seen) st = ST_ERR;
                        else begin
                            nxt.phase         = PH_VALUE;
                            nxt.space_pending = cur.value_seen;
                        end
                    end else begin
                        if (cur.name_seen) begin
                            hdone             = 1'b1;
                            nxt.name_seen     = 1'b0;
                            nxt.value_seen    = 1'b0;
                            nxt.space_pending = 1'b0;
                        end
                        if (c == CH_CR) nxt.phase = PH_NL_3;
                        else if (is_token(c)) begin
                            kind          = K_NAME;
                            nxt.name_seen = 1'b1;
                            nxt.phase     = PH_NAME;
                        end else st = ST_ERR;
                    end
                end
                PH_NAME: begin
                    if (c == CH_COLON) nxt.phase = PH_VALUE;
                    else if (is_token(c)) kind = K_NAME;
                    else st = ST_ERR;
                end
                PH_VALUE: begin
                    if (c == CH_CR) nxt.phase = PH_NL_2;
                    else if (is_ws) nxt.space_pending = cur.value_seen;
                    else if (is_ctl(c)) st = ST_ERR;
                    else begin
                        kind              = K_VALUE;
                        ins               = cur.space_pending;
                        nxt.space_pending = 1'b0;
                        nxt.value_seen    = 1'b1;
                    end
                end
                PH_NL_3: begin
                    st = (c == CH_LF) ? ST_DONE : ST_ERR;
                end
                default: st = ST_ERR;
            endcase
            nxt.final_status = st;
        end
    end

    assign o_state             = nxt;
    assign o_rsp.field_kind    = kind;
    assign o_rsp.out_byte      = (kind != K_NONE) ? c : 8'h00;
    assign o_rsp.insert_space  = ins;
    assign o_rsp.header_done   = hdone;
    assign o_rsp.status        = st;

endmodule

[rtl/http_request_head_parser_top.sv]
// Top level of the HTTP request head parser: input register, grammar step, result register.
//
// Streams an HTTP request head one byte per request and returns one result per byte:
// the field tag of the byte (method, URI, version, header name, header value, or none for
// delimiters), the byte itself, an insert-space flag for collapsed whitespace in header
// values, a header-done flag when a name/value pair has ended, and the running status
// (need more, complete, error). Complete and error are held, and further bytes ignored,
// until a request arrives with start_new set, which clears the parser before that byte.
// Throughput is one byte per clock while the result side is not stalled; a byte is captured in
// the input register, and its result passes through the combinational grammar step into the
// result register. The parser state advances only when a byte moves from the input register
// into the result register, so stalls on the result side simply hold everything in place.
module http_request_head_parser_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte requests in
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  hrp_pkg::t_in_req  i_req,
    // results out
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output hrp_pkg::t_out_rsp o_rsp
);
    import hrp_pkg::*;

    // input register
    logic     r_in_valid;
    t_in_req  r_in;
    // parser state
    t_state   r_state;
    t_state   n_state;
    // result register
    logic     r_out_valid;
    t_out_rsp r_out;
    t_out_rsp n_out;

    logic advance;   // input register moves into result register
    logic take_in;   // new request captured

    // Result register can be loaded when empty or being drained this cycle.
    assign advance     = r_in_valid && (!r_out_valid || i_rsp_ready);
    // Input register frees up when empty or when it advances.
    assign o_req_ready = !r_in_valid || advance;
    assign take_in     = i_req_valid && o_req_ready;

    hrp_step u_step (
        .i_state (r_state),
        .i_req   (r_in),
        .o_state (n_state),
        .o_rsp   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (take_in) r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (take_in) r_in  <= i_req;
        if (advance) r_out <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule
